// ----- hw/rtl/dq_pkg.sv -----
package dq_pkg;

  // Width of one queue entry.
  localparam int unsigned WordW = 32;

  // Operation selector carried with each input request.
  typedef enum logic [1:0] {
    KIND_PUSH_FRONT = 2'd0,
    KIND_PUSH_REAR  = 2'd1,
    KIND_POP_FRONT  = 2'd2,
    KIND_POP_REAR   = 2'd3
  } dq_kind_t;

  // Completion status returned with each result.
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2
  } dq_status_t;

  // Command broadcast from the controller to every cell of the row.
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_PUSH_FRONT,
    CMD_PUSH_REAR,
    CMD_POP_FRONT,
    CMD_POP_REAR
  } dq_cmd_op_t;

  typedef struct packed {
    dq_cmd_op_t        op;
    logic [WordW-1:0]  push_word;
  } dq_cmd_t;

  // Controller sequencing states.
  typedef enum logic {
    ST_IDLE,
    ST_SWEEP
  } dq_state_t;

endpackage

// ----- hw/rtl/dq_cell.sv -----
module dq_cell
  import dq_pkg::*;
#(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned INDEX = 0
) (
  input  logic                           clk,
  input  dq_cmd_t                        cmd,
  input  logic [$clog2(DEPTH+1)-1:0]     count,
  input  logic [WordW-1:0]               left_word,
  input  logic [WordW-1:0]               right_word,
  input  logic [WordW-1:0]               pick_in,
  output logic [WordW-1:0]               word,
  output logic [WordW-1:0]               pick
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WordW-1:0] word_r, word_nxt;
  logic [WordW-1:0] pick_r, pick_nxt;
  logic             is_rear_slot;
  logic             is_last_entry;

  // This cell is the first free slot, or the last held entry.
  assign is_rear_slot  = (count == CntW'(INDEX));
  assign is_last_entry = (count == CntW'(INDEX + 1));

  // Entry update: shift toward the rear, shift toward the front, or load.
  always_comb begin
    word_nxt = word_r;
    unique case (cmd.op)
      CMD_PUSH_FRONT: begin
        word_nxt = (INDEX == 0) ? cmd.push_word : left_word;
      end
      CMD_PUSH_REAR: begin
        if (is_rear_slot) begin
          word_nxt = cmd.push_word;
        end
      end
      CMD_POP_FRONT: begin
        word_nxt = right_word;
      end
      CMD_HOLD, CMD_POP_REAR: begin
        word_nxt = word_r;
      end
      default: begin
        word_nxt = word_r;
      end
    endcase
  end

  // The pick line moves the popped rear entry one cell toward the tail a cycle.
  always_comb begin
    if (cmd.op == CMD_POP_REAR && is_last_entry) begin
      pick_nxt = word_r;
    end else begin
      pick_nxt = pick_in;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    pick_r <= pick_nxt;
  end

  assign word = word_r;
  assign pick = pick_r;

endmodule

// ----- hw/rtl/dq_ctrl.sv -----
module dq_ctrl
  import dq_pkg::*;
#(
  parameter int unsigned DEPTH = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  dq_kind_t                       in_kind,
  input  logic [WordW-1:0]               in_word,
  input  logic [WordW-1:0]               head_word,
  input  logic [WordW-1:0]               pick_tail,
  output dq_cmd_t                        cmd,
  output logic [$clog2(DEPTH+1)-1:0]     count,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_status,
  output logic [WordW-1:0]               out_word,
  output logic [3:0]                     out_fill
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned IdxW = $clog2(DEPTH);

  dq_state_t         state_r, state_nxt;
  logic [CntW-1:0]   count_r, count_nxt;
  logic [IdxW-1:0]   rem_r, rem_nxt;
  logic              out_valid_r, out_valid_nxt;
  dq_status_t        status_r, status_nxt;
  logic [WordW-1:0]  pop_r, pop_nxt;
  logic [CntW-1:0]   fill_r, fill_nxt;
  logic [CntW-1:0]   gap;
  logic [CntW+3:0]   fill_ext;
  logic              full;
  logic              empty;
  logic              take;

  assign full  = (count_r == CntW'(DEPTH));
  assign empty = (count_r == '0);
  assign gap   = CntW'(DEPTH) - count_r;

  // A new request waits until the sequencer is idle and the result slot frees.
  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign take     = in_valid && in_ready;

  // Next state, cell command and result.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r && !out_ready;
    status_nxt    = status_r;
    pop_nxt       = pop_r;
    fill_nxt      = fill_r;
    cmd.op        = CMD_HOLD;
    cmd.push_word = in_word;

    unique case (state_r)
      ST_IDLE: begin
        if (take) begin
          unique case (in_kind)
            KIND_PUSH_FRONT, KIND_PUSH_REAR: begin
              out_valid_nxt = 1'b1;
              pop_nxt       = '0;
              if (full) begin
                status_nxt = STAT_OVERFLOW;
                fill_nxt   = count_r;
              end else begin
                cmd.op     = (in_kind == KIND_PUSH_FRONT) ? CMD_PUSH_FRONT : CMD_PUSH_REAR;
                count_nxt  = count_r + 1'b1;
                status_nxt = STAT_OK;
                fill_nxt   = count_r + 1'b1;
              end
            end
            KIND_POP_FRONT: begin
              out_valid_nxt = 1'b1;
              if (empty) begin
                status_nxt = STAT_UNDERFLOW;
                pop_nxt    = '0;
                fill_nxt   = count_r;
              end else begin
                cmd.op     = CMD_POP_FRONT;
                count_nxt  = count_r - 1'b1;
                status_nxt = STAT_OK;
                pop_nxt    = head_word;
                fill_nxt   = count_r - 1'b1;
              end
            end
            KIND_POP_REAR: begin
              if (empty) begin
                out_valid_nxt = 1'b1;
                status_nxt    = STAT_UNDERFLOW;
                pop_nxt       = '0;
                fill_nxt      = count_r;
              end else begin
                // The rear entry travels down the pick line to the tail cell.
                cmd.op    = CMD_POP_REAR;
                count_nxt = count_r - 1'b1;
                rem_nxt   = gap[IdxW-1:0];
                state_nxt = ST_SWEEP;
              end
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_SWEEP: begin
        if (rem_r == '0) begin
          out_valid_nxt = 1'b1;
          status_nxt    = STAT_OK;
          pop_nxt       = pick_tail;
          fill_nxt      = count_r;
          state_nxt     = ST_IDLE;
        end else begin
          rem_nxt = rem_r - 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload and sweep distance.
  always_ff @(posedge clk) begin
    rem_r    <= rem_nxt;
    status_r <= status_nxt;
    pop_r    <= pop_nxt;
    fill_r   <= fill_nxt;
  end

  // The reported count keeps its low four bits.
  assign fill_ext   = {4'b0000, fill_r};
  assign count      = count_r;
  assign out_valid  = out_valid_r;
  assign out_status = status_r;
  assign out_word   = pop_r;
  assign out_fill   = fill_ext[3:0];

endmodule

// ----- hw/rtl/double_ended_queue_core.sv -----
// Bounded double-ended queue built as a row of DEPTH entry cells, front at cell 0.
// Pushes, front pops and failed requests return their result in the cycle after acceptance.
// A rear pop sends the entry down a registered pick line to the tail cell,
// and its result is returned once the entry reaches the tail.
// One request in flight: one request per cycle while results are taken, a rear pop excepted.
// Synchronous active-low reset empties the queue; entry contents are not cleared.
module double_ended_queue_core
  import dq_pkg::*;
#(
  parameter int unsigned DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] push_value
  input  logic [1:0]  in_tuser,   // [1:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] pop_value, [35:32] fill_count, [39:36] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  dq_cmd_t           cmd;
  logic [CntW-1:0]   count;
  logic [WordW-1:0]  word_w [DEPTH];
  logic [WordW-1:0]  pick_w [DEPTH];
  logic [WordW-1:0]  pop_word;
  logic [3:0]        fill;

  // Sequencer, fill count and result register.
  dq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_kind    (dq_kind_t'(in_tuser)),
    .in_word    (in_tdata),
    .head_word  (word_w[0]),
    .pick_tail  (pick_w[DEPTH-1]),
    .cmd        (cmd),
    .count      (count),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (out_tuser),
    .out_word   (pop_word),
    .out_fill   (fill)
  );

  // Row of entry cells, each linked to its neighbors.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WordW-1:0] left_word;
    logic [WordW-1:0] right_word;
    logic [WordW-1:0] pick_in;

    if (i == 0) begin : g_first
      assign left_word = '0;
      assign pick_in   = '0;
    end else begin : g_inner
      assign left_word = word_w[i-1];
      assign pick_in   = pick_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_word = '0;
    end else begin : g_notlast
      assign right_word = word_w[i+1];
    end

    dq_cell #(
      .DEPTH (DEPTH),
      .INDEX (i)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .count      (count),
      .left_word  (left_word),
      .right_word (right_word),
      .pick_in    (pick_in),
      .word       (word_w[i]),
      .pick       (pick_w[i])
    );
  end

  assign out_tdata = {4'b0000, fill, pop_word};

endmodule
